/* hw/rtl/qat_pkg.sv */
// shared types and constants for the quoted argument tokenizer
package qat_pkg;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [2:0] KIND_BYTE        = 3'd0;
  localparam logic [2:0] KIND_ARG_END     = 3'd1;
  localparam logic [2:0] KIND_ACCEPT      = 3'd2;
  localparam logic [2:0] KIND_TRAIL_BSL   = 3'd3;
  localparam logic [2:0] KIND_OPEN_SINGLE = 3'd4;
  localparam logic [2:0] KIND_OPEN_DOUBLE = 3'd5;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_EOL  = 1'b1;

  localparam logic [3:0] ARG_CAP_RESET = 4'd9;
  localparam logic [9:0] MAX_LEN_RESET = 10'd1023;

  localparam logic REG_ARG_CAP = 1'b0;
  localparam logic REG_MAX_LEN = 1'b1;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [3:0] idx;
  } res_t;

  // one classified input item: one or two results
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* hw/rtl/quoted_argument_tokenizer.sv */
// top level of the quoted argument tokenizer
// Splits a command line, one byte per input transaction and closed by an
// end-of-line transaction (in_tuser high), into argument bytes, argument ends
// and a line status. One input transaction is taken per clock while the
// entry queue has room; the front end classifies it as it is accepted, the
// entry is queued at that clock edge, and the back end loads the queued
// results one at a time into the output register while it is empty or taken.
// Items that give two results (an argument closed at end of line, a kept
// backslash in double quotes) leave the queue more slowly than they enter,
// so a long run of them fills the queue of QUEUE_DEPTH entries and then holds
// input back. Bytes streamed for a line that then ends in error are not
// withdrawn; the error result marks the line to be dropped. Limits are set on
// the APB port at byte addresses 0 (max_arguments) and 4 (max_argument_length).
module quoted_argument_tokenizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] line_byte
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [11:8] argument_index
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [3:0]       arg_cap_r;
  logic [9:0]       max_len_r;
  logic             cfg_wr;
  logic             q_push;
  logic             q_pop;
  qat_pkg::entry_t  q_in;
  qat_pkg::entry_t  q_head;
  qat_pkg::q_stat_t q_stat;
  qat_pkg::res_t    res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == qat_pkg::REG_MAX_LEN) ? {22'd0, max_len_r}
                                                             : {28'd0, arg_cap_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arg_cap_r <= qat_pkg::ARG_CAP_RESET;
      max_len_r <= qat_pkg::MAX_LEN_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == qat_pkg::REG_ARG_CAP) begin
        arg_cap_r <= cfg_pwdata[3:0];
      end else begin
        max_len_r <= cfg_pwdata[9:0];
      end
    end
  end

  assign in_tready = !q_stat.full;

  qat_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid && in_tready),
    .item_cmd   (in_tuser),
    .item_byte  (in_tdata),
    .arg_cap    (arg_cap_r),
    .max_len    (max_len_r),
    .push       (q_push),
    .entry      (q_in)
  );

  qat_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  qat_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .stat      (q_stat),
    .pop       (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res),
    .res_last  (out_tlast)
  );

  assign out_tdata = {4'd0, res.idx, res.data};
  assign out_tuser = res.kind;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("entry pushed into a full queue");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != qat_pkg::KIND_BYTE) |-> out_tdata[7:0] == 8'd0)
    else $error("non-byte result carries a byte");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != qat_pkg::KIND_BYTE && out_tuser != qat_pkg::KIND_ARG_END)
      |-> out_tlast)
    else $error("line status is not the final result of its transaction");

endmodule

/* hw/rtl/qat_front.sv */
// front end: accepts line items, tracks quoting state and builds result entries
module qat_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  logic             item_cmd,
  input  logic [7:0]       item_byte,
  input  logic [3:0]       arg_cap,
  input  logic [9:0]       max_len,
  output logic             push,
  output qat_pkg::entry_t  entry
);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_SINGLE = 2'd2,
    MODE_DOUBLE = 2'd3
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic        esc_r, esc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [9:0]  len_r, len_nxt;

  always_comb begin
    mode_t         m;
    logic          e;
    logic [9:0]    l;
    logic          skip;
    logic          ok1;
    logic          ok2;
    qat_pkg::res_t rb;
    qat_pkg::res_t rs;
    qat_pkg::res_t re;
    m        = mode_r;
    e        = esc_r;
    l        = len_r;
    skip     = 1'b0;
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    push     = 1'b0;
    entry    = '0;
    rb       = '{kind: qat_pkg::KIND_BYTE, data: item_byte, idx: cnt_r};
    rs       = '{kind: qat_pkg::KIND_BYTE, data: qat_pkg::CH_BSLASH, idx: cnt_r};
    re       = '{kind: qat_pkg::KIND_ARG_END, data: 8'd0, idx: cnt_r};
    if (mode_r == MODE_IDLE) begin
      e = 1'b0;
      l = '0;
    end
    ok1 = l < max_len;
    ok2 = ok1 && (({1'b0, l} + 11'd1) < {1'b0, max_len});
    if (item_valid) begin
      if (item_cmd == qat_pkg::CMD_EOL) begin
        push     = 1'b1;
        entry.r0 = '{kind: qat_pkg::KIND_ACCEPT, data: 8'd0, idx: cnt_r};
        if (cnt_r < arg_cap) begin
          case (mode_r)
            MODE_PLAIN: begin
              if (esc_r) begin
                entry.r0.kind = qat_pkg::KIND_TRAIL_BSL;
              end else begin
                entry.two = 1'b1;
                entry.r0  = re;
                entry.r1  = '{kind: qat_pkg::KIND_ACCEPT, data: 8'd0, idx: cnt_r + 4'd1};
              end
            end
            MODE_SINGLE: entry.r0.kind = qat_pkg::KIND_OPEN_SINGLE;
            MODE_DOUBLE: entry.r0.kind = qat_pkg::KIND_OPEN_DOUBLE;
            default: ;
          endcase
        end
        mode_nxt = MODE_IDLE;
        esc_nxt  = 1'b0;
        cnt_nxt  = '0;
        len_nxt  = '0;
      end else if (cnt_r < arg_cap) begin
        if (mode_r == MODE_IDLE) begin
          if (item_byte == qat_pkg::CH_SPACE) begin
            skip = 1'b1;
          end else begin
            m = MODE_PLAIN;
          end
        end
        if (!skip) begin
          mode_nxt = m;
          esc_nxt  = e;
          len_nxt  = l;
          case (m)
            MODE_PLAIN: begin
              if (e) begin
                esc_nxt = 1'b0;
                if (ok1) begin
                  push     = 1'b1;
                  entry.r0 = rb;
                  len_nxt  = l + 10'd1;
                end
              end else if (item_byte == qat_pkg::CH_SQUOTE) begin
                mode_nxt = MODE_SINGLE;
              end else if (item_byte == qat_pkg::CH_DQUOTE) begin
                mode_nxt = MODE_DOUBLE;
              end else if (item_byte == qat_pkg::CH_BSLASH) begin
                esc_nxt = 1'b1;
              end else if (item_byte == qat_pkg::CH_SPACE) begin
                push     = 1'b1;
                entry.r0 = re;
                cnt_nxt  = cnt_r + 4'd1;
                mode_nxt = MODE_IDLE;
                esc_nxt  = 1'b0;
                len_nxt  = '0;
              end else if (ok1) begin
                push     = 1'b1;
                entry.r0 = rb;
                len_nxt  = l + 10'd1;
              end
            end
            MODE_SINGLE: begin
              if (item_byte == qat_pkg::CH_SQUOTE) begin
                push     = 1'b1;
                entry.r0 = re;
                cnt_nxt  = cnt_r + 4'd1;
                mode_nxt = MODE_IDLE;
                esc_nxt  = 1'b0;
                len_nxt  = '0;
              end else if (ok1) begin
                push     = 1'b1;
                entry.r0 = rb;
                len_nxt  = l + 10'd1;
              end
            end
            MODE_DOUBLE: begin
              if (e) begin
                esc_nxt = 1'b0;
                if (item_byte == qat_pkg::CH_DQUOTE || item_byte == qat_pkg::CH_BSLASH ||
                    item_byte == qat_pkg::CH_DOLLAR || item_byte == qat_pkg::CH_NEWLINE) begin
                  if (ok1) begin
                    push     = 1'b1;
                    entry.r0 = rb;
                    len_nxt  = l + 10'd1;
                  end
                end else if (ok1) begin
                  // kept backslash, then the byte itself if room remains
                  push     = 1'b1;
                  entry.r0 = rs;
                  len_nxt  = l + 10'd1;
                  if (ok2) begin
                    entry.two = 1'b1;
                    entry.r1  = rb;
                    len_nxt   = l + 10'd2;
                  end
                end
              end else if (item_byte == qat_pkg::CH_DQUOTE) begin
                push     = 1'b1;
                entry.r0 = re;
                cnt_nxt  = cnt_r + 4'd1;
                mode_nxt = MODE_IDLE;
                esc_nxt  = 1'b0;
                len_nxt  = '0;
              end else if (item_byte == qat_pkg::CH_BSLASH) begin
                esc_nxt = 1'b1;
              end else if (ok1) begin
                push     = 1'b1;
                entry.r0 = rb;
                len_nxt  = l + 10'd1;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      esc_r  <= 1'b0;
      cnt_r  <= '0;
      len_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      cnt_r  <= cnt_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

/* hw/rtl/qat_queue.sv */
// small entry queue between the front end and the back end
module qat_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  qat_pkg::entry_t  push_data,
  input  logic             pop,
  output qat_pkg::entry_t  head,
  output qat_pkg::q_stat_t stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  qat_pkg::entry_t   mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat.full  = cnt_r == CNT_W'(DEPTH);
  assign stat.empty = cnt_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/qat_back.sv */
// back end: unpacks queued entries into single results on an output register
module qat_back (
  input  logic             clk,
  input  logic             rst_n,
  input  qat_pkg::entry_t  head,
  input  qat_pkg::q_stat_t stat,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_ready,
  output qat_pkg::res_t    res,
  output logic             res_last
);

  logic          valid_r, valid_nxt;
  logic          phase_r, phase_nxt;
  qat_pkg::res_t res_r, res_nxt;
  logic          last_r, last_nxt;
  logic          load;
  logic          final_slot;

  assign load       = (!valid_r || res_ready) && !stat.empty;
  assign final_slot = !head.two || phase_r;
  assign pop        = load && final_slot;

  always_comb begin
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    res_nxt   = res_r;
    last_nxt  = last_r;
    if (res_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = phase_r ? head.r1 : head.r0;
      last_nxt  = final_slot;
      phase_nxt = !final_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
    res_r  <= res_nxt;
    last_r <= last_nxt;
  end

  assign res_valid = valid_r;
  assign res       = res_r;
  assign res_last  = last_r;

endmodule
